// File: design/irdx_pkg.sv
// Shared constants and helper functions for the radix digit converter.
package irdx_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int VALUE_W        = 32;
  localparam int RADIX_W        = 6;
  localparam int CHAR_W         = 7;
  localparam int TDATA_OUT_W    = 8;
  localparam int DIV_BITS       = 4;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] DEC_LIMIT   = 6'd10;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'd48;
  localparam logic [CHAR_W-1:0]  CHAR_A      = 7'd97;

  function automatic logic [RADIX_W-1:0] effective_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] e;
    e = r;
    if (r < RADIX_MIN) e = RADIX_MIN;
    if (r > RADIX_MAX) e = RADIX_MAX;
    return e;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d >= DEC_LIMIT) begin
      c = CHAR_A + CHAR_W'(d - DEC_LIMIT);
    end else begin
      c = CHAR_ZERO + CHAR_W'(d);
    end
    return c;
  endfunction

endpackage

// File: design/irdx_front.sv
// Front end: radix register, input beat acceptance and a two-entry job queue.
module irdx_front import irdx_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [RADIX_W-1:0]    cfg_wdata,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [VALUE_W-1:0]    s_axis_tdata,
  output logic                  q_valid,
  output logic [VALUE_BITS-1:0] q_value,
  output logic [RADIX_W-1:0]    q_radix,
  input  logic                  q_pop
);

  logic [RADIX_W-1:0]    radix;
  logic [VALUE_BITS-1:0] val_mem [2];
  logic [RADIX_W-1:0]    rad_mem [2];
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            count;
  logic                  push;
  logic                  pop;

  assign s_axis_tready = (count != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid       = (count != 2'd0);
  assign pop           = q_pop && q_valid;
  assign q_value       = val_mem[rd_ptr];
  assign q_radix       = rad_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_we) begin
      radix <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      val_mem[wr_ptr] <= VALUE_BITS'(s_axis_tdata);
      rad_mem[wr_ptr] <= effective_radix(radix);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// File: design/irdx_div.sv
// Iterative divider by a small radix, four quotient bits per cycle.
module irdx_div import irdx_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [RADIX_W-1:0]    divisor,
  output logic                  done,
  output logic [VALUE_BITS-1:0] quotient,
  output logic [RADIX_W-1:0]    remainder
);

  localparam int STEPS  = (VALUE_BITS + DIV_BITS - 1) / DIV_BITS;
  localparam int WP     = STEPS * DIV_BITS;
  localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic [WP-1:0]      q;
  logic [RADIX_W-1:0] r;
  logic [RADIX_W-1:0] b;
  logic [STEP_W-1:0]  step;
  logic               busy;
  logic [WP-1:0]      q_next;
  logic [RADIX_W-1:0] r_next;

  always_comb begin
    logic [RADIX_W:0] r7;
    q_next = q;
    r_next = r;
    for (int i = 0; i < DIV_BITS; i++) begin
      r7     = {r_next, q_next[WP-1]};
      q_next = {q_next[WP-2:0], 1'b0};
      if (r7 >= {1'b0, b}) begin
        r_next    = RADIX_W'(r7 - {1'b0, b});
        q_next[0] = 1'b1;
      end else begin
        r_next = r7[RADIX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= WP'(dividend);
      r <= '0;
      b <= divisor;
    end else if (busy) begin
      q <= q_next;
      r <= r_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = q[VALUE_BITS-1:0];
  assign remainder = r;

endmodule

// File: design/irdx_back.sv
// Back end: digit extraction sequencer, digit stack and output register.
module irdx_back import irdx_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  logic [VALUE_BITS-1:0]  q_value,
  input  logic [RADIX_W-1:0]     q_radix,
  output logic                   q_pop,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [TDATA_OUT_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast
);

  localparam int AW = $clog2(VALUE_BITS);
  localparam int CW = $clog2(VALUE_BITS + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_READ = 4'b0100,
    S_LOAD = 4'b1000
  } state_t;

  state_t                state;
  state_t                state_next;
  logic [CW-1:0]         cnt;
  logic [RADIX_W-1:0]    b;
  logic [RADIX_W-1:0]    stack_mem [VALUE_BITS];
  logic [RADIX_W-1:0]    rd_data;
  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic [RADIX_W-1:0]    div_divisor;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quo;
  logic [RADIX_W-1:0]    div_rem;
  logic                  out_free;
  logic                  load_out;
  logic                  wr_en;
  logic                  rd_en;

  assign out_free     = !m_axis_tvalid || m_axis_tready;
  assign q_pop        = (state == S_IDLE) && q_valid;
  assign wr_en        = (state == S_DIV) && div_done;
  assign rd_en        = (state == S_READ);
  assign load_out     = (state == S_LOAD) && out_free;
  assign div_start    = q_pop || (wr_en && (div_quo != '0));
  assign div_dividend = (state == S_IDLE) ? q_value : div_quo;
  assign div_divisor  = (state == S_IDLE) ? q_radix : b;

  irdx_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (q_valid) state_next = S_DIV;
      S_DIV:  if (div_done && (div_quo == '0)) state_next = S_READ;
      S_READ: state_next = S_LOAD;
      S_LOAD: begin
        if (out_free) state_next = (cnt == '0) ? S_IDLE : S_READ;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        cnt <= '0;
      end else if (wr_en) begin
        cnt <= cnt + 1'b1;
      end else if (rd_en) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) b <= q_radix;
  end

  always_ff @(posedge clk) begin
    if (wr_en) stack_mem[cnt[AW-1:0]] <= div_rem;
    if (rd_en) rd_data <= stack_mem[AW'(cnt - 1'b1)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tdata <= TDATA_OUT_W'(digit_to_ascii(rd_data));
      m_axis_tlast <= (cnt == '0);
    end
  end

endmodule

// File: design/integer_to_radix_digits_core.sv
// Top level of the integer to ASCII radix digit converter.
// Each input beat carries one unsigned integer, of which the low VALUE_BITS bits are used;
// it is written in the base held in the radix register (values below 2 act as 2, above 36
// as 36) and sent out as one output beat per ASCII digit ('0'-'9', 'a'-'z'), most
// significant first, with tlast on the final digit. Zero gives a single '0'. Each digit
// is the remainder of one division in the shared divider, which retires four quotient
// bits per cycle, and the digits are then read back off the digit stack. A two-entry
// input queue takes new beats while a number is being converted. The user must write the
// radix register only while the block is idle; the block itself does not enforce this.
module integer_to_radix_digits_core import irdx_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [RADIX_W-1:0]     cfg_wdata,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [VALUE_W-1:0]     s_axis_tdata,  // [31:0] value
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [TDATA_OUT_W-1:0] m_axis_tdata,  // [6:0] digit_char, [7] zero fill
  output logic                   m_axis_tlast
);

  logic                  q_valid;
  logic [VALUE_BITS-1:0] q_value;
  logic [RADIX_W-1:0]    q_radix;
  logic                  q_pop;

  irdx_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_valid       (q_valid),
    .q_value       (q_value),
    .q_radix       (q_radix),
    .q_pop         (q_pop)
  );

  irdx_back #(
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_value       (q_value),
    .q_radix       (q_radix),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// File: design/irdx_checker.sv
// Port-level checker for the radix digit converter, bound to the top level.
module irdx_checker import irdx_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [TDATA_OUT_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("Output beat dropped while stalled.");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("Output beat changed while stalled.");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata >= 8'd48) && (m_axis_tdata <= 8'd122))
    else $error("Output character outside the digit range.");

  a_char_gap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !((m_axis_tdata > 8'd57) && (m_axis_tdata < 8'd97)))
    else $error("Output character is not a digit or a lowercase letter.");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("Output beat valid right after reset.");

endmodule

bind integer_to_radix_digits_core irdx_checker u_irdx_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// File: bench/tb.sv
// Testbench for the integer to radix digit converter: directed and random numbers checked digit by digit.
module tb;
  import irdx_pkg::*;

  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } digit_beat_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [RADIX_W-1:0]     cfg_wdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [VALUE_W-1:0]     s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  digit_beat_t        pending_digits[$];
  logic [RADIX_W-1:0] radix_now = RADIX_RESET;
  logic [36:0]        bases_used = '0;
  int                 error_count = 0;
  int                 numbers_sent = 0;
  int                 digits_seen = 0;
  int                 quiet_cycles = 0;
  bit                 idle_on = 1'b1;

  integer_to_radix_digits_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("MISMATCH: %s: got %0h, expected %0h", what, got, want);
  endtask

  // Digits come out of the division least significant first, so each is put in front.
  function automatic void push_digits_of(input logic [VALUE_W-1:0] v,
                                         input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] base;
    logic [RADIX_W-1:0] digits[$];
    logic [VALUE_W-1:0] n;
    digit_beat_t        b;
    base = r;
    if (r < RADIX_MIN) base = RADIX_MIN;
    if (r > RADIX_MAX) base = RADIX_MAX;
    bases_used[base] = 1'b1;
    n = v;
    do begin
      digits.push_front(RADIX_W'(n % base));
      n = n / base;
    end while (n != 0);
    foreach (digits[k]) begin
      if (digits[k] >= DEC_LIMIT) begin
        b.ch = CHAR_A + CHAR_W'(digits[k] - DEC_LIMIT);
      end else begin
        b.ch = CHAR_ZERO + CHAR_W'(digits[k]);
      end
      b.last = (k == digits.size() - 1);
      pending_digits.push_back(b);
    end
  endfunction

  always @(posedge clk) begin : digit_monitor
    digit_beat_t want;
    if (rst) begin
      radix_now = RADIX_RESET;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        digits_seen++;
        if (pending_digits.size() == 0) begin
          report_mismatch("digit beat with nothing expected", 32'(m_axis_tdata), 32'd0);
        end else begin
          want = pending_digits.pop_front();
          if (m_axis_tdata[CHAR_W-1:0] !== want.ch) begin
            report_mismatch("digit_char", 32'(m_axis_tdata[CHAR_W-1:0]), 32'(want.ch));
          end
          if (m_axis_tdata[TDATA_OUT_W-1:CHAR_W] !== '0) begin
            report_mismatch("zero fill of tdata", 32'(m_axis_tdata), 32'(want.ch));
          end
          if (m_axis_tlast !== want.last) begin
            report_mismatch("last_digit", 32'(m_axis_tlast), 32'(want.last));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        numbers_sent++;
        push_digits_of(s_axis_tdata, radix_now);
      end
      if (cfg_we) radix_now = cfg_wdata;
    end
  end

  always @(posedge clk) begin : output_stalls
    int stall_left;
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("Stalled for %0d cycles with no beat accepted.", STALL_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_value(input logic [VALUE_W-1:0] v);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (pending_digits.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_radix(input logic [RADIX_W-1:0] r);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic test_default_radix();
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'd9);
    send_value(32'd10);
    send_value(32'd12345);
    send_value(32'hFFFF_FFFF);
  endtask

  task automatic test_binary_and_clamp_low();
    set_radix(6'd2);
    send_value(32'hFFFF_FFFF);
    send_value(32'h8000_0000);
    send_value(32'd0);
    set_radix(6'd0);
    send_value(32'd5);
    set_radix(6'd1);
    send_value(32'hAAAA_AAAA);
  endtask

  task automatic test_letter_digits();
    set_radix(6'd11);
    send_value(32'd10);
    send_value(32'd120);
    set_radix(6'd16);
    send_value(32'hDEAD_BEEF);
    send_value(32'h0000_FFFF);
    set_radix(6'd36);
    send_value(32'd35);
    send_value(32'd36);
    send_value(32'hFFFF_FFFF);
    set_radix(6'd37);
    send_value(32'd35);
    set_radix(6'd63);
    send_value(32'hFFFF_FFFF);
  endtask

  // Each phase picks a base, then sends a mix of full-width, small and shortened values.
  task automatic test_random_numbers();
    logic [RADIX_W-1:0] phase_radix[9];
    logic [VALUE_W-1:0] v;
    phase_radix = '{6'd2, 6'd36, 6'd16, 6'd8, 6'd10, 6'd3, 6'd0, 6'd0, 6'd0};
    for (int p = 0; p < 9; p++) begin
      if (p >= 6) phase_radix[p] = RADIX_W'($urandom_range(0, 63));
      if (p == 8) idle_on = 1'b0;
      set_radix(phase_radix[p]);
      for (int i = 0; i < 28; i++) begin
        case ($urandom_range(0, 3))
          0: v = $urandom;
          1: v = $urandom_range(0, 255);
          2: v = $urandom >> $urandom_range(0, 31);
          default: v = 32'hFFFF_FFFF - $urandom_range(0, 3);
        endcase
        send_value(v);
        if (i == 13) wait_drained();
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_radix();
    test_binary_and_clamp_low();
    test_letter_digits();
    test_random_numbers();
    wait_drained();
    repeat (50) @(posedge clk);
    while (pending_digits.size() != 0) begin
      void'(pending_digits.pop_front());
      report_mismatch("expected digit never arrived", 32'd0, 32'd0);
    end
    $display("Converted %0d numbers into %0d digit beats, using %0d different bases.",
             numbers_sent, digits_seen, $countones(bases_used));
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
